// File: hw/rtl/tia_pkg.sv
// Shared types, codes and default sizes for the typed ID allocator.
// Used by tia_scan and typed_id_allocator; depends on nothing else.
`default_nettype none

package tia_pkg;

  localparam int ID_W = 32;
  localparam int CLAIMED_DEPTH_DEF = 64;
  localparam int FREE_DEPTH_DEF = 64;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_CLAIMED_FULL = 2'd1;
  localparam logic [1:0] ST_FREE_FULL    = 2'd2;
  localparam logic [1:0] ST_NOT_CLAIMED  = 2'd3;

  // Launch of one table scan.
  typedef struct packed {
    logic            go;
    logic            overlap;
    logic [ID_W-1:0] key;
  } scan_ctl_t;

  // Outcome of a scan, valid for the one cycle in which done is high.
  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/tia_scan.sv
// Shared scan and compare unit: walks one table entry per cycle through a registered memory port.
// Depends on tia_pkg for the scan control and result structs.
`default_nettype none

module tia_scan import tia_pkg::*; #(
  parameter int DEPTH = CLAIMED_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire scan_ctl_t                    ctl,
  input  wire logic [$clog2(DEPTH+1)-1:0]   limit,
  input  wire logic [ID_W-1:0]              rd_data,
  output logic                              rd_en,
  output logic [$clog2(DEPTH)-1:0]          rd_addr,
  output scan_res_t                         res,
  output logic [$clog2(DEPTH)-1:0]          hit_idx
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic            active;
  logic            overlap;
  logic [ID_W-1:0] key;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   issue_idx;
  logic            cmp_valid;
  logic [IW-1:0]   cmp_idx;
  logic            match;
  logic            issuing;

  // Equality for table lookups, any shared bit for the type search.
  assign match   = overlap ? ((rd_data & key) != '0) : (rd_data == key);
  assign issuing = active && (issue_idx != lim);

  assign rd_en   = issuing;
  assign rd_addr = issue_idx[IW-1:0];
  assign hit_idx = cmp_idx;

  assign res.hit  = active && cmp_valid && match;
  assign res.done = active && ((cmp_valid && match) || (!cmp_valid && !issuing));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cmp_valid <= 1'b0;
      issue_idx <= '0;
    end else if (ctl.go) begin
      active    <= 1'b1;
      overlap   <= ctl.overlap;
      key       <= ctl.key;
      lim       <= limit;
      issue_idx <= '0;
      cmp_valid <= 1'b0;
    end else if (active) begin
      if (res.done) begin
        active    <= 1'b0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= issuing;
        if (issuing) begin
          cmp_idx   <= issue_idx[IW-1:0];
          issue_idx <= issue_idx + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/typed_id_allocator.sv
// Top level of the typed ID allocator: command sequencer, claimed table and free list.
// Depends on tia_pkg and on the shared scan unit tia_scan.
`default_nettype none

// Usage
// A command word (cmd, type_bits, entity_id) is taken at a rising edge where start is high
// and busy is low. busy then stays high until the result word appears: result_id, success,
// id_valid and status are shown for exactly one cycle with done high, and busy is already
// low in that cycle, so the next command may be issued alongside the result. The receiver
// cannot stall the block; it must take the result word in the cycle that done marks it.
// The type mask register is to be written by the user with cfg_wen and cfg_wdata only while
// no command is in flight; the block itself does not enforce this. Every lookup walks a table
// through the single scan unit, one entry per cycle through the registered memory read port.
// A query stops at the first slot that holds the ID or after all claimed_count entries; a
// release that hits then reads the last claimed entry and moves it into the hole. An
// allocation that reuses a free-list entry likewise moves the last free entry into its slot.
// A probing allocation runs one claimed-table scan per probe, at most CLAIMED_DEPTH + 2
// probes, after any free-list scan of up to FREE_DEPTH entries.
// Reset clears the counter, both fill counts and the type mask; the tables need no clearing
// pass since only entries below the fill counts are ever read.

module typed_id_allocator import tia_pkg::*; #(
  parameter int CLAIMED_DEPTH = CLAIMED_DEPTH_DEF,
  parameter int FREE_DEPTH    = FREE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wen,
  input  wire logic [ID_W-1:0] cfg_wdata,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      cmd,
  input  wire logic [ID_W-1:0] type_bits,
  input  wire logic [ID_W-1:0] entity_id,
  output logic                 done,
  output logic [ID_W-1:0]      result_id,
  output logic                 success,
  output logic                 id_valid,
  output logic [1:0]           status
);

  localparam int CAW = $clog2(CLAIMED_DEPTH);
  localparam int FAW = $clog2(FREE_DEPTH);
  localparam int CCW = $clog2(CLAIMED_DEPTH + 1);
  localparam int FCW = $clog2(FREE_DEPTH + 1);
  localparam int SCAN_DEPTH = (CLAIMED_DEPTH > FREE_DEPTH) ? CLAIMED_DEPTH : FREE_DEPTH;
  localparam int SIW = $clog2(SCAN_DEPTH);
  localparam int SCW = $clog2(SCAN_DEPTH + 1);
  localparam int STW = $clog2(CLAIMED_DEPTH + 2);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FSCAN = 4'd1;  // search the free list for a shared type bit
  localparam logic [3:0] S_FMRD  = 4'd2;  // read the last free entry
  localparam logic [3:0] S_FMWR  = 4'd3;  // move it into the hole
  localparam logic [3:0] S_PSCAN = 4'd4;  // look up one probe in the claimed table
  localparam logic [3:0] S_CFIND = 4'd5;  // look up entity_id in the claimed table
  localparam logic [3:0] S_CMRD  = 4'd6;  // read the last claimed entry
  localparam logic [3:0] S_CMWR  = 4'd7;  // move it into the hole
  localparam logic [3:0] S_FIN   = 4'd8;  // commit pushes and present the result

  logic [3:0]      state;
  logic [ID_W-1:0] kind_mask;
  logic [1:0]      cmd_r;
  logic [ID_W-1:0] tsel;
  logic [ID_W-1:0] res;
  logic            ok;
  logic [1:0]      stat;
  logic [ID_W-1:0] ctr;
  logic [ID_W-1:0] start_v;
  logic [STW-1:0]  steps;
  logic [SIW-1:0]  hit_idx;
  logic [CCW-1:0]  cc;
  logic [FCW-1:0]  fc;
  logic            scan_go;

  logic [ID_W-1:0] claimed_mem [CLAIMED_DEPTH];
  logic [ID_W-1:0] free_mem    [FREE_DEPTH];
  logic [ID_W-1:0] claimed_rd;
  logic [ID_W-1:0] free_rd;

  logic [ID_W-1:0] cmask;
  logic [ID_W-1:0] cand;
  logic [ID_W-1:0] cand_fail;
  logic [ID_W-1:0] req_type;
  logic            res_valid;
  logic [CCW-1:0]  cc_last;
  logic [FCW-1:0]  fc_last;
  logic            alloc_push;
  logic            rel_push;

  scan_ctl_t       scan_ctl;
  scan_res_t       scan_res;
  logic [SCW-1:0]  scan_limit;
  logic [ID_W-1:0] scan_rd;
  logic            scan_rd_en;
  logic [SIW-1:0]  scan_addr;
  logic [SIW-1:0]  scan_idx;
  logic            scan_free;

  logic            claimed_ren;
  logic [CAW-1:0]  claimed_raddr;
  logic            claimed_we;
  logic [CAW-1:0]  claimed_waddr;
  logic [ID_W-1:0] claimed_wdata;
  logic            free_ren;
  logic [FAW-1:0]  free_raddr;
  logic            free_we;
  logic [FAW-1:0]  free_waddr;
  logic [ID_W-1:0] free_wdata;

  // Counter bits are the bits outside the type mask; an ID with all of them set is invalid.
  assign cmask     = ~kind_mask;
  assign cand      = ctr | tsel;
  assign cand_fail = cand | cmask;
  assign req_type  = type_bits & kind_mask;
  assign res_valid = (res & cmask) != cmask;
  assign cc_last   = cc - CCW'(1);
  assign fc_last   = fc - FCW'(1);

  // The claimed table is known to have room on the allocate path unless full was flagged.
  assign alloc_push = (cmd_r == CMD_ALLOC) && (stat != ST_CLAIMED_FULL) && res_valid;
  assign rel_push   = (cmd_r == CMD_RELEASE) && (fc < FCW'(FREE_DEPTH));

  // One scan unit serves both tables; the state tells which one it walks.
  assign scan_free        = (state == S_FSCAN);
  assign scan_ctl.go      = scan_go;
  assign scan_ctl.overlap = scan_free;
  assign scan_ctl.key     = scan_free ? tsel : ((state == S_PSCAN) ? cand : res);
  assign scan_limit       = scan_free ? SCW'(fc) : SCW'(cc);
  assign scan_rd          = scan_free ? free_rd : claimed_rd;

  tia_scan #(
    .DEPTH (SCAN_DEPTH)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .limit   (scan_limit),
    .rd_data (scan_rd),
    .rd_en   (scan_rd_en),
    .rd_addr (scan_addr),
    .res     (scan_res),
    .hit_idx (scan_idx)
  );

  // Claimed table port selection: scan reads, swap-on-remove, and append on allocate.
  assign claimed_ren   = (state == S_CMRD) || (scan_rd_en && !scan_free);
  assign claimed_raddr = (state == S_CMRD) ? cc_last[CAW-1:0] : scan_addr[CAW-1:0];
  assign claimed_we    = (state == S_CMWR) || ((state == S_FIN) && alloc_push);
  assign claimed_waddr = (state == S_CMWR) ? hit_idx[CAW-1:0] : cc[CAW-1:0];
  assign claimed_wdata = (state == S_CMWR) ? claimed_rd : res;

  // Free list port selection: scan reads, swap-on-take, and push on release.
  assign free_ren   = (state == S_FMRD) || (scan_rd_en && scan_free);
  assign free_raddr = (state == S_FMRD) ? fc_last[FAW-1:0] : scan_addr[FAW-1:0];
  assign free_we    = (state == S_FMWR) || ((state == S_FIN) && rel_push);
  assign free_waddr = (state == S_FMWR) ? hit_idx[FAW-1:0] : fc[FAW-1:0];
  assign free_wdata = (state == S_FMWR) ? free_rd : res;

  always_ff @(posedge clk) begin
    if (claimed_ren) begin
      claimed_rd <= claimed_mem[claimed_raddr];
    end
    if (claimed_we) begin
      claimed_mem[claimed_waddr] <= claimed_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (free_ren) begin
      free_rd <= free_mem[free_raddr];
    end
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      done      <= 1'b0;
      scan_go   <= 1'b0;
      kind_mask <= '0;
      ctr       <= '0;
      cc        <= '0;
      fc        <= '0;
    end else begin
      done    <= 1'b0;
      scan_go <= 1'b0;
      if (cfg_wen) begin
        kind_mask <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            busy  <= 1'b1;
            cmd_r <= cmd;
            tsel  <= req_type;
            res   <= entity_id;
            ok    <= 1'b0;
            stat  <= ST_OK;
            unique case (cmd)
              CMD_ALLOC: begin
                if (cc == CCW'(CLAIMED_DEPTH)) begin
                  // No room: answer with an invalid ID of the requested type.
                  res   <= req_type | cmask;
                  stat  <= ST_CLAIMED_FULL;
                  state <= S_FIN;
                end else if ((req_type != '0) && (fc != '0)) begin
                  scan_go <= 1'b1;
                  state   <= S_FSCAN;
                end else begin
                  start_v <= ctr - ID_W'(1);
                  steps   <= '0;
                  scan_go <= 1'b1;
                  state   <= S_PSCAN;
                end
              end
              default: begin
                scan_go <= 1'b1;
                state   <= S_CFIND;
              end
            endcase
          end
        end
        S_FSCAN: begin
          if (scan_res.done) begin
            if (scan_res.hit) begin
              res     <= scan_rd;
              hit_idx <= scan_idx;
              state   <= S_FMRD;
            end else begin
              start_v <= ctr - ID_W'(1);
              steps   <= '0;
              scan_go <= 1'b1;
              state   <= S_PSCAN;
            end
          end
        end
        S_FMRD: begin
          state <= S_FMWR;
        end
        S_FMWR: begin
          fc    <= fc_last;
          state <= S_FIN;
        end
        S_PSCAN: begin
          if (scan_res.done) begin
            if (!scan_res.hit) begin
              // Wrapping all the way round counts as failure even on a free probe.
              res   <= (ctr == start_v) ? cand_fail : cand;
              state <= S_FIN;
            end else if ((ctr == start_v) || (steps > STW'(CLAIMED_DEPTH))) begin
              res   <= cand_fail;
              state <= S_FIN;
            end else begin
              ctr     <= (ctr + ID_W'(1)) & cmask;
              steps   <= steps + STW'(1);
              scan_go <= 1'b1;
            end
          end
        end
        S_CFIND: begin
          if (scan_res.done) begin
            ok <= scan_res.hit;
            if (scan_res.hit) begin
              hit_idx <= scan_idx;
              state   <= (cmd_r == CMD_RELEASE) ? S_CMRD : S_FIN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CMRD: begin
          state <= S_CMWR;
        end
        S_CMWR: begin
          cc    <= cc_last;
          state <= S_FIN;
        end
        S_FIN: begin
          done      <= 1'b1;
          busy      <= 1'b0;
          state     <= S_IDLE;
          result_id <= res;
          id_valid  <= res_valid;
          unique case (cmd_r)
            CMD_ALLOC: begin
              success <= alloc_push;
              status  <= stat;
              if (alloc_push) begin
                cc <= cc + CCW'(1);
              end
            end
            CMD_RELEASE: begin
              success <= ok;
              if (rel_push) begin
                fc     <= fc + FCW'(1);
                status <= ok ? ST_OK : ST_NOT_CLAIMED;
              end else begin
                status <= ST_FREE_FULL;
              end
            end
            default: begin
              success <= ok;
              status  <= ok ? ST_OK : ST_NOT_CLAIMED;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cc_bound: assert property (@(posedge clk) disable iff (rst)
    cc <= CCW'(CLAIMED_DEPTH))
    else $error("claimed count exceeds table depth");

  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    fc <= FCW'(FREE_DEPTH))
    else $error("free count exceeds list depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && state == S_IDLE && $past(state) == S_FIN))
    else $error("result word shown outside the finish step");

  a_cc_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cc != $past(cc)) |-> ($past(state) == S_FIN || $past(state) == S_CMWR))
    else $error("claimed count changed outside a commit step");
`endif

endmodule

`default_nettype wire

// File: test/tb_typed_id_allocator.sv
// Self-checking testbench for typed_id_allocator: allocate, release and query words with
// an in-bench prediction of the claimed table, free list and counter.
// Depends on tia_pkg and the typed_id_allocator RTL only.
`default_nettype none

module tb_typed_id_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import tia_pkg::*;

  localparam int CLAIMED_DEPTH = CLAIMED_DEPTH_DEF;
  localparam int FREE_DEPTH    = FREE_DEPTH_DEF;

  // Command code 3 is unused by the block and must behave like a query.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int WORDS_PER_MASK = 150;
  localparam int REPORT_CAP     = 200;

  // Slowest legal word: a probing allocation that walks the claimed table
  // CLAIMED_DEPTH + 2 times, plus a generous sender gap. Taken four times over.
  localparam longint WORST_WORD_CYCLES = 4700;
  localparam longint LIMIT_NS = 64'd2000 * WORST_WORD_CYCLES * 4 * 10;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            success;
    logic            valid;
    logic [1:0]      status;
  } alloc_answer_t;

  // Block ports. Every input has a known value from time zero.
  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wen = 1'b0;
  logic [ID_W-1:0] cfg_wdata = '0;
  logic            start = 1'b0;
  logic            busy;
  logic [1:0]      cmd = CMD_ALLOC;
  logic [ID_W-1:0] type_bits = '0;
  logic [ID_W-1:0] entity_id = '0;
  logic            done;
  logic [ID_W-1:0] result_id;
  logic            success;
  logic            id_valid;
  logic [1:0]      status;

  // Predicted state of the block. The tables keep the block's slot order, since the
  // free-list scan takes the first match and both tables swap the last entry into a hole.
  logic [ID_W-1:0] kind_mask_now = '0;
  logic [ID_W-1:0] id_ctr = '0;
  logic [ID_W-1:0] claimed_ids [CLAIMED_DEPTH];
  int              claimed_n = 0;
  logic [ID_W-1:0] free_ids [FREE_DEPTH];
  int              free_n = 0;

  alloc_answer_t answers_due [$];

  int sender_idle_pct = 0;
  int words_sent = 0;
  int words_checked = 0;
  int failures = 0;
  int mask_writes = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  typed_id_allocator #(
    .CLAIMED_DEPTH(CLAIMED_DEPTH),
    .FREE_DEPTH   (FREE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .type_bits(type_bits),
    .entity_id(entity_id),
    .done     (done),
    .result_id(result_id),
    .success  (success),
    .id_valid (id_valid),
    .status   (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hang guard, sized from the slowest correct run.
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------

  // Slot of the first claimed copy of an ID, or -1 when it is not claimed.
  function automatic int claimed_slot(input logic [ID_W-1:0] id);
    for (int i = 0; i < claimed_n; i++) begin
      if (claimed_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Works out the answer to one accepted command word and updates the predicted state.
  function automatic alloc_answer_t allocator_answer(input logic [1:0] op,
                                                     input logic [ID_W-1:0] req_type,
                                                     input logic [ID_W-1:0] eid);
    logic [ID_W-1:0] cmask;
    logic [ID_W-1:0] kind;
    logic [ID_W-1:0] res;
    logic [ID_W-1:0] wrap_at;
    logic [ID_W-1:0] probe;
    int              steps;
    int              where;
    bit              hit;
    bit              gave_up;
    alloc_answer_t   ans;
    cmask = ~kind_mask_now;
    res = '0;
    ans.success = 1'b0;
    ans.status = ST_OK;
    if (op == CMD_ALLOC) begin
      kind = req_type & kind_mask_now;
      if (claimed_n >= CLAIMED_DEPTH) begin
        // No room: nothing changes and the answer is the invalid ID of that type.
        res = kind | cmask;
        ans.status = ST_CLAIMED_FULL;
      end else begin
        hit = 1'b0;
        // A zero type never reuses a free entry; otherwise take the first one that
        // shares a type bit and fill its slot with the last entry.
        if (kind != '0) begin
          for (int i = 0; i < free_n; i++) begin
            if ((free_ids[i] & kind) != '0) begin
              res = free_ids[i];
              free_ids[i] = free_ids[free_n - 1];
              free_n--;
              hit = 1'b1;
              break;
            end
          end
        end
        if (!hit) begin
          // Probe counter values until one is free. The walk gives up when the counter
          // comes back to just below where it began or after too many steps.
          wrap_at = id_ctr - 1'b1;
          probe = id_ctr | kind;
          steps = 0;
          gave_up = 1'b0;
          while (claimed_slot(probe) >= 0) begin
            if (id_ctr == wrap_at || steps > CLAIMED_DEPTH) begin
              gave_up = 1'b1;
              break;
            end
            id_ctr = (id_ctr + 1'b1) & cmask;
            probe = id_ctr | kind;
            steps++;
          end
          if (id_ctr == wrap_at) gave_up = 1'b1;
          res = gave_up ? (probe | cmask) : probe;
        end
        // Only a valid ID is entered into the claimed table.
        if ((res & cmask) != cmask) begin
          claimed_ids[claimed_n] = res;
          claimed_n++;
          ans.success = 1'b1;
        end
      end
    end else if (op == CMD_RELEASE) begin
      res = eid;
      where = claimed_slot(res);
      if (where >= 0) begin
        claimed_ids[where] = claimed_ids[claimed_n - 1];
        claimed_n--;
        ans.success = 1'b1;
      end
      // The ID goes onto the free list whether or not it was claimed; a full list drops
      // it, and that outcome outranks the not-claimed code.
      if (free_n < FREE_DEPTH) begin
        free_ids[free_n] = res;
        free_n++;
        ans.status = ans.success ? ST_OK : ST_NOT_CLAIMED;
      end else begin
        ans.status = ST_FREE_FULL;
      end
    end else begin
      // Query, and the unused code that decodes as one.
      res = eid;
      ans.success = (claimed_slot(res) >= 0);
      ans.status = ans.success ? ST_OK : ST_NOT_CLAIMED;
    end
    ans.id = res;
    ans.valid = ((res & cmask) != cmask);
    return ans;
  endfunction

  // ---------------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------------

  // Sends one command word. Start is left high on return so a word that follows right
  // away keeps it high; a gap or a drain lowers it in a later time step.
  task automatic send_word(input logic [1:0] op, input logic [ID_W-1:0] req_type,
                           input logic [ID_W-1:0] eid);
    while ($urandom_range(99) < sender_idle_pct) begin
      // Junk on the fields while start is low must be ignored by the block.
      start <= 1'b0;
      cmd <= 2'($urandom());
      type_bits <= $urandom();
      entity_id <= $urandom();
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    type_bits <= req_type;
    entity_id <= eid;
    // The word is taken at the first edge that sees start high and busy low.
    do @(posedge clk); while (busy !== 1'b0);
    answers_due = {answers_due, allocator_answer(op, req_type, eid)};
    words_sent++;
  endtask

  // Lowers start and waits until every outstanding result word has come back, plus a
  // few cycles so the sequencer is surely back in its idle state.
  task automatic drain_words();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The type mask is only written while the block is idle.
  task automatic write_kind_mask(input logic [ID_W-1:0] mask);
    drain_words();
    cfg_wen <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    kind_mask_now = mask;
    mask_writes++;
    cfg_wen <= 1'b0;
    cfg_wdata <= $urandom();
  endtask

  // Requested types: mostly bits inside the mask so that free entries get reused, with
  // some zero types and some values with bits outside the mask.
  function automatic logic [ID_W-1:0] pick_type();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return '0;
      2:       return kind_mask_now & (~kind_mask_now + 1'b1);
      3:       return 32'h1 << $urandom_range(31);
      default: return $urandom() & kind_mask_now;
    endcase
  endfunction

  // IDs for release and query: mostly ones that are claimed or on the free list, the
  // rest arbitrary or invalid (all counter bits set).
  function automatic logic [ID_W-1:0] pick_entity();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return (claimed_n > 0) ? claimed_ids[$urandom_range(claimed_n - 1)]
                                               : $urandom();
      6, 7:             return (free_n > 0) ? free_ids[$urandom_range(free_n - 1)] : '1;
      8:                return $urandom();
      default:          return $urandom() | ~kind_mask_now;
    endcase
  endfunction

  // One random word. Allocation is held back when the claimed table is nearly full so
  // that the table keeps filling and emptying instead of sitting full.
  task automatic send_random_word();
    int         roll;
    logic [1:0] op;
    roll = $urandom_range(99);
    if (roll < ((claimed_n >= CLAIMED_DEPTH - 4) ? 25 : 45)) op = CMD_ALLOC;
    else if (roll < 75) op = CMD_RELEASE;
    else if (roll < 97) op = CMD_QUERY;
    else op = CMD_SPARE;
    send_word(op, pick_type(), pick_entity());
  endtask

  // ---------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
    failures++;
    if (failures <= REPORT_CAP) begin
      $error("%s: expected %h, got %h", field, want, got);
    end else if (failures == REPORT_CAP + 1) begin
      $display("further mismatch reports suppressed");
    end
  endtask

  // Each result word is shown for exactly one cycle and cannot be held off, so it is
  // sampled at the edge that ends that cycle.
  always @(posedge clk) begin
    alloc_answer_t due;
    if (!rst && done === 1'b1) begin
      words_checked++;
      if (!$isunknown(status)) status_seen[status]++;
      if (answers_due.size() == 0) begin
        note_mismatch("unexpected result_id", '0, result_id);
      end else begin
        due = answers_due.pop_front();
        if (result_id !== due.id)     note_mismatch("result_id", due.id, result_id);
        if (success !== due.success)  note_mismatch("success", due.success, success);
        if (id_valid !== due.valid)   note_mismatch("id_valid", due.valid, id_valid);
        if (status !== due.status)    note_mismatch("status", due.status, status);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // Hand-picked words from the reset state: type bits outside the mask, reuse of a free
  // entry, reuse of an invalid free entry, release of unclaimed and invalid IDs, the
  // unused command code and the all-zero and all-one field values.
  task automatic test_directed();
    sender_idle_pct = 0;
    write_kind_mask(32'hFF00_0000);
    send_word(CMD_ALLOC,   32'h0000_0000, 32'hFFFF_FFFF);
    send_word(CMD_ALLOC,   32'h0100_0000, 32'h0000_0000);
    send_word(CMD_ALLOC,   32'hFFFF_FFFF, 32'h0000_0000);
    send_word(CMD_QUERY,   32'h0000_0000, 32'h0100_0000);
    send_word(CMD_QUERY,   32'hFFFF_FFFF, 32'h1234_5678);
    send_word(CMD_RELEASE, 32'h0000_0000, 32'h0100_0000);
    send_word(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    // The first free entry shares the requested bit and comes back as a claim.
    send_word(CMD_ALLOC,   32'h0100_0000, 32'h0000_0000);
    // The remaining free entry is invalid: handed out, but not claimed.
    send_word(CMD_ALLOC,   32'h8000_0000, 32'h0000_0000);
    send_word(CMD_SPARE,   32'hFFFF_FFFF, 32'h0000_0000);
    send_word(CMD_RELEASE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_word(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_word(CMD_QUERY,   32'h0000_0000, 32'hFFFF_FFFF);
    send_word(CMD_QUERY,   32'h0000_0000, 32'h00FF_FFFF);
    send_word(CMD_RELEASE, 32'h0000_0000, 32'h7E5A_0000);
    // All requested bits fall outside the mask, so the type is zero and no free entry
    // may be reused even though one shares those bits.
    send_word(CMD_ALLOC,   32'h00FF_FFFF, 32'h0000_0000);
    send_word(CMD_SPARE,   32'h0000_0000, 32'h0000_0001);
  endtask

  // Drives the probe walk to both of its give-up conditions. Counter values 0..7 are
  // claimed under a four-bit counter; shrinking the counter to three bits turns ID 7
  // into the invalid pattern, so every probe is taken until the counter reaches just
  // below its start. Freeing 0 then parks the counter at zero, whose predecessor can
  // never come up again, and the next walk stops on the step limit instead.
  task automatic test_probe_exhaustion();
    int guard;
    sender_idle_pct = 10;
    write_kind_mask(32'hFFFF_FFF0);
    guard = 0;
    while (claimed_slot(32'h7) < 0 && guard < 16) begin
      send_word(CMD_ALLOC, 32'h0, $urandom());
      guard++;
    end
    write_kind_mask(32'hFFFF_FFF8);
    repeat (2) send_word(CMD_ALLOC, 32'h0, $urandom());
    send_word(CMD_RELEASE, $urandom(), 32'h0);
    repeat (2) send_word(CMD_ALLOC, 32'h0, $urandom());
    send_word(CMD_QUERY, $urandom(), 32'h7);
  endtask

  // Fills the claimed table, asks for more, then opens single slots again.
  task automatic test_claimed_table_full();
    int guard;
    sender_idle_pct = 10;
    write_kind_mask(32'hFFFF_0000);
    guard = 0;
    while (claimed_n < CLAIMED_DEPTH && guard < 3 * CLAIMED_DEPTH) begin
      send_word(CMD_ALLOC, $urandom(), $urandom());
      guard++;
    end
    repeat (4) send_word(CMD_ALLOC, $urandom(), $urandom());
    send_word(CMD_ALLOC, 32'h0, 32'h0);
    send_word(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_QUERY, $urandom(), pick_entity());
    send_word(CMD_RELEASE, $urandom(), pick_entity());
    send_word(CMD_ALLOC, $urandom(), $urandom());
    send_word(CMD_ALLOC, $urandom(), $urandom());
  endtask

  // With a zero mask no allocation drains the free list, so releases fill it; further
  // releases of claimed and unclaimed IDs are then dropped.
  task automatic test_free_list_full();
    int guard;
    sender_idle_pct = 0;
    write_kind_mask(32'h0);
    guard = 0;
    while (free_n < FREE_DEPTH && guard < 3 * FREE_DEPTH) begin
      send_word(CMD_RELEASE, $urandom(), pick_entity());
      guard++;
    end
    repeat (3) begin
      if (claimed_n > 0) send_word(CMD_RELEASE, $urandom(), claimed_ids[0]);
      send_word(CMD_RELEASE, $urandom(), $urandom());
    end
    send_word(CMD_ALLOC, $urandom(), $urandom());
    // An all-ones mask lets allocations pull entries off the full list again.
    write_kind_mask(32'hFFFF_FFFF);
    repeat (6) send_word(CMD_ALLOC, $urandom(), $urandom());
    send_word(CMD_RELEASE, $urandom(), $urandom());
  endtask

  // Random traffic under four type mask settings at one sender pacing.
  task automatic test_mixed_traffic(input int idle_pct, input logic [ID_W-1:0] m0,
                                    input logic [ID_W-1:0] m1, input logic [ID_W-1:0] m2,
                                    input logic [ID_W-1:0] m3);
    logic [ID_W-1:0] masks [4];
    masks = '{m0, m1, m2, m3};
    sender_idle_pct = idle_pct;
    foreach (masks[k]) begin
      write_kind_mask(masks[k]);
      repeat (WORDS_PER_MASK) send_random_word();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_probe_exhaustion();
    test_claimed_table_full();
    test_free_list_full();
    test_mixed_traffic(0,  32'h0000_0000, 32'hFFFF_0000, $urandom(), 32'hFFFF_FFF0);
    test_mixed_traffic(74, 32'hFFFF_FFFF, $urandom(), 32'h0000_FFFF, 32'hFFFF_FFF8);
    test_mixed_traffic(10, $urandom(), 32'hF0F0_F0F0, 32'h8000_0001, 32'h0000_0000);

    // Let every outstanding word come back, then watch for strays a while longer.
    drain_words();
    repeat (200) @(posedge clk);

    $display("covered %0d command words under %0d type mask settings, sender idle 0/74/10%%",
             words_sent, mask_writes);
    $display("checked %0d results: ok %0d, claimed full %0d, free full %0d, not claimed %0d",
             words_checked, status_seen[ST_OK], status_seen[ST_CLAIMED_FULL],
             status_seen[ST_FREE_FULL], status_seen[ST_NOT_CLAIMED]);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: typed_id_allocator.f
hw/rtl/tia_pkg.sv
hw/rtl/tia_scan.sv
hw/rtl/typed_id_allocator.sv
test/tb_typed_id_allocator.sv
